[rtl/fat32bsc_pkg.sv]
// ----------------------------------------------------------------------------
// FAT32 boot sector geometry check package
// Status codes, field layouts, pipeline plan and constants shared by the block.
// ----------------------------------------------------------------------------
package fat32bsc_pkg;

   localparam logic [7:0]  JMP_SHORT   = 8'hEB;
   localparam logic [7:0]  NOP_OPCODE  = 8'h90;
   localparam logic [7:0]  JMP_NEAR    = 8'hE9;
   localparam logic [15:0] END_MARK    = 16'hAA55;

   localparam logic [23:0] MAX_CLUSTER_BYTES = 24'd32768;
   localparam logic [31:0] MIN_CLUSTERS      = 32'd65536;
   localparam logic [31:0] MAX_CLUSTERS      = 32'd268435445;

   localparam int STEP_BITS   = 4;
   localparam int ROOT_QW     = 12;
   localparam int CLUS_QW     = 32;
   localparam int ROOT_STAGES = ROOT_QW / STEP_BITS;
   localparam int CLUS_STAGES = CLUS_QW / STEP_BITS;

   localparam int ROOT_FIRST  = 1;
   localparam int ROOT_LAST   = ROOT_STAGES;
   localparam int SUM_STAGE   = ROOT_LAST + 1;
   localparam int CLUS_FIRST  = SUM_STAGE + 1;
   localparam int CLUS_LAST   = SUM_STAGE + CLUS_STAGES;
   localparam int LATE_STAGE  = CLUS_LAST + 1;
   localparam int PIPE_DEPTH  = LATE_STAGE + 1;

   localparam int REQ_W = 160;
   localparam int RSP_W = 136;

   typedef enum logic [3:0] {
      ST_OK           = 4'd0,
      ST_JUMP         = 4'd1,
      ST_MARKER       = 4'd2,
      ST_BPS_ZERO     = 4'd3,
      ST_BPS_ALIGN    = 4'd4,
      ST_SPC_ZERO     = 4'd5,
      ST_CLUSTER_SIZE = 4'd6,
      ST_RSVD_ZERO    = 4'd7,
      ST_FATS_ZERO    = 4'd8,
      ST_ROOT_ALIGN   = 4'd9,
      ST_TOTAL_ZERO   = 4'd10,
      ST_NO_CLUSTERS  = 4'd11,
      ST_NOT_FAT32    = 4'd12,
      ST_FATSZ_ZERO   = 4'd13,
      ST_ROOT_NONZERO = 4'd14,
      ST_TOO_MANY     = 4'd15
   } status_type;

   typedef struct packed {
      logic [31:0] fat_sectors;
      logic [31:0] total_sectors;
      logic [15:0] root_entries;
      logic [7:0]  fat_copies;
      logic [15:0] reserved_sectors;
      logic [7:0]  sectors_per_cluster;
      logic [15:0] bytes_per_sector;
      logic [15:0] end_marker;
      logic [7:0]  jump_byte2;
      logic [7:0]  jump_byte0;
   } req_type;

   typedef struct packed {
      logic        pad;
      logic [43:0] volume_bytes;
      logic [10:0] entries_per_cluster;
      logic [15:0] cluster_bytes;
      logic [31:0] first_data_sector;
      logic [27:0] cluster_count;
      status_type  status;
   } rsp_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] cbytes;
      logic [7:0]  spc;
      logic [6:0]  rdiv;
      logic [6:0]  rrem;
      logic [ROOT_QW-1:0] rq;
      logic [15:0] rsvd;
      logic [31:0] fatprod;
      logic [31:0] base;
      logic [31:0] total;
      logic [31:0] fds;
      logic [7:0]  crem;
      logic [CLUS_QW-1:0] cq;
      logic        fat_zero;
      logic        root_nz;
      logic [43:0] vbytes;
   } pipe_type;

endpackage

[rtl/fat32_boot_sector_check_geometry.sv]
// ----------------------------------------------------------------------------
// FAT32 boot sector geometry check
// Validates the boot sector fields of a volume and derives its FAT32 geometry.
// ----------------------------------------------------------------------------
// Each request on the req_ channel carries the boot sector fields of one
// volume. Each request gives exactly one result on the rsp_ channel: a status
// code, which is zero when every check passes or else names the first failed
// check, and the geometry of the volume, which is all zero on error.
// The block is a 15-stage pipeline with one request in flight per stage.
// A new request is taken in every cycle while the receiver does not stall, so
// the sustained rate is one request per cycle. The two restoring dividers
// give four quotient bits per stage: 12 bits for the root directory sectors
// and 32 bits for the clusters.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops; nothing is lost or repeated.
// Reset clears all valid bits, so no result is shown until new requests come.
// ----------------------------------------------------------------------------
module fat32_boot_sector_check_geometry (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // jump_byte0, jump_byte2, end_marker, bytes_per_sector, sectors_per_cluster,
   // reserved_sectors, fat_copies, root_entries, total_sectors, fat_sectors
   input  logic [159:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, cluster_count, first_data_sector, cluster_bytes,
   // entries_per_cluster, volume_bytes, zero pad
   output logic [135:0] rsp_tdata
);

   localparam int DEPTH = fat32bsc_pkg::PIPE_DEPTH;

   fat32bsc_pkg::req_type  req;
   fat32bsc_pkg::pipe_type pipe_ff [DEPTH];
   fat32bsc_pkg::pipe_type pipe_in [DEPTH];
   logic [DEPTH-1:0]       vld_ff;
   fat32bsc_pkg::rsp_type  rsp_ff;
   fat32bsc_pkg::rsp_type  rsp_in;
   logic                   rsp_tvalid_ff;
   logic                   adv;

   assign req        = fat32bsc_pkg::req_type'(req_tdata);
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_ff;

   always_comb begin
      logic [23:0] csize;
      logic [7:0]  rtrial;
      logic [6:0]  rrem;
      logic [fat32bsc_pkg::ROOT_QW-1:0] rq;
      logic [8:0]  ctrial;
      logic [7:0]  crem;
      logic [fat32bsc_pkg::CLUS_QW-1:0] cq;
      logic [31:0] rds;
      logic [31:0] data;
      logic [27:0] mul_a;
      logic [15:0] mul_b;

      for (int k = 1; k < DEPTH; k++) begin
         pipe_in[k] = pipe_ff[k-1];
      end

      // Stage 0: early checks and the two small products.
      csize = 24'(req.sectors_per_cluster) * 24'(req.bytes_per_sector);
      pipe_in[0]          = pipe_ff[0];
      pipe_in[0].cbytes   = csize[15:0];
      pipe_in[0].spc      = req.sectors_per_cluster;
      pipe_in[0].rdiv     = req.bytes_per_sector[15:9];
      pipe_in[0].rrem     = '0;
      pipe_in[0].rq       = req.root_entries[15:4];
      pipe_in[0].rsvd     = req.reserved_sectors;
      pipe_in[0].fatprod  = 32'(req.fat_copies) * req.fat_sectors;
      pipe_in[0].total    = req.total_sectors;
      pipe_in[0].fat_zero = (req.fat_sectors == '0);
      pipe_in[0].root_nz  = (req.root_entries != '0);
      priority if (!((req.jump_byte0 == fat32bsc_pkg::JMP_SHORT) &&
                     (req.jump_byte2 == fat32bsc_pkg::NOP_OPCODE)) &&
                   (req.jump_byte0 != fat32bsc_pkg::JMP_NEAR)) begin
         pipe_in[0].status = fat32bsc_pkg::ST_JUMP;
      end else if (req.end_marker != fat32bsc_pkg::END_MARK) begin
         pipe_in[0].status = fat32bsc_pkg::ST_MARKER;
      end else if (req.bytes_per_sector == '0) begin
         pipe_in[0].status = fat32bsc_pkg::ST_BPS_ZERO;
      end else if (req.bytes_per_sector[8:0] != '0) begin
         pipe_in[0].status = fat32bsc_pkg::ST_BPS_ALIGN;
      end else if (req.sectors_per_cluster == '0) begin
         pipe_in[0].status = fat32bsc_pkg::ST_SPC_ZERO;
      end else if (csize > fat32bsc_pkg::MAX_CLUSTER_BYTES) begin
         pipe_in[0].status = fat32bsc_pkg::ST_CLUSTER_SIZE;
      end else if (req.reserved_sectors == '0) begin
         pipe_in[0].status = fat32bsc_pkg::ST_RSVD_ZERO;
      end else if (req.fat_copies == '0) begin
         pipe_in[0].status = fat32bsc_pkg::ST_FATS_ZERO;
      end else if (req.root_entries[4:0] != '0) begin
         pipe_in[0].status = fat32bsc_pkg::ST_ROOT_ALIGN;
      end else if (req.total_sectors == '0) begin
         pipe_in[0].status = fat32bsc_pkg::ST_TOTAL_ZERO;
      end else begin
         pipe_in[0].status = fat32bsc_pkg::ST_OK;
      end

      // Root directory sectors: sixteenths of the entry count over the
      // sector size in units of 512 bytes, rounded up.
      pipe_in[fat32bsc_pkg::ROOT_FIRST].base =
         32'(pipe_ff[fat32bsc_pkg::ROOT_FIRST-1].rsvd) +
         pipe_ff[fat32bsc_pkg::ROOT_FIRST-1].fatprod;
      for (int k = fat32bsc_pkg::ROOT_FIRST; k <= fat32bsc_pkg::ROOT_LAST; k++) begin
         rrem = pipe_ff[k-1].rrem;
         rq   = pipe_ff[k-1].rq;
         for (int j = 0; j < fat32bsc_pkg::STEP_BITS; j++) begin
            rtrial = {rrem, rq[fat32bsc_pkg::ROOT_QW-1]};
            rq     = {rq[fat32bsc_pkg::ROOT_QW-2:0], 1'b0};
            if (rtrial >= {1'b0, pipe_ff[k-1].rdiv}) begin
               rtrial = rtrial - {1'b0, pipe_ff[k-1].rdiv};
               rq[0]  = 1'b1;
            end
            rrem = rtrial[6:0];
         end
         pipe_in[k].rrem = rrem;
         pipe_in[k].rq   = rq;
      end

      // First data sector and data sector count.
      rds  = 32'(pipe_ff[fat32bsc_pkg::SUM_STAGE-1].rq) +
             32'(pipe_ff[fat32bsc_pkg::SUM_STAGE-1].rrem != '0);
      data = pipe_ff[fat32bsc_pkg::SUM_STAGE-1].total -
             pipe_ff[fat32bsc_pkg::SUM_STAGE-1].base - rds;
      pipe_in[fat32bsc_pkg::SUM_STAGE].fds  = pipe_ff[fat32bsc_pkg::SUM_STAGE-1].base + rds;
      pipe_in[fat32bsc_pkg::SUM_STAGE].cq   = data[31] ? '0 : data;
      pipe_in[fat32bsc_pkg::SUM_STAGE].crem = '0;

      // Cluster count: data sectors over sectors per cluster.
      for (int k = fat32bsc_pkg::CLUS_FIRST; k <= fat32bsc_pkg::CLUS_LAST; k++) begin
         crem = pipe_ff[k-1].crem;
         cq   = pipe_ff[k-1].cq;
         for (int j = 0; j < fat32bsc_pkg::STEP_BITS; j++) begin
            ctrial = {crem, cq[fat32bsc_pkg::CLUS_QW-1]};
            cq     = {cq[fat32bsc_pkg::CLUS_QW-2:0], 1'b0};
            if (ctrial >= {1'b0, pipe_ff[k-1].spc}) begin
               ctrial = ctrial - {1'b0, pipe_ff[k-1].spc};
               cq[0]  = 1'b1;
            end
            crem = ctrial[7:0];
         end
         pipe_in[k].crem = crem;
         pipe_in[k].cq   = cq;
      end

      // Late checks and volume size.
      mul_a = pipe_ff[fat32bsc_pkg::LATE_STAGE-1].cq[27:0];
      mul_b = pipe_ff[fat32bsc_pkg::LATE_STAGE-1].cbytes;
      pipe_in[fat32bsc_pkg::LATE_STAGE].vbytes = 44'(mul_a) * 44'(mul_b);
      cq = pipe_ff[fat32bsc_pkg::LATE_STAGE-1].cq;
      if (pipe_ff[fat32bsc_pkg::LATE_STAGE-1].status == fat32bsc_pkg::ST_OK) begin
         priority if (cq == '0) begin
            pipe_in[fat32bsc_pkg::LATE_STAGE].status = fat32bsc_pkg::ST_NO_CLUSTERS;
         end else if (cq <= fat32bsc_pkg::MIN_CLUSTERS) begin
            pipe_in[fat32bsc_pkg::LATE_STAGE].status = fat32bsc_pkg::ST_NOT_FAT32;
         end else if (pipe_ff[fat32bsc_pkg::LATE_STAGE-1].fat_zero) begin
            pipe_in[fat32bsc_pkg::LATE_STAGE].status = fat32bsc_pkg::ST_FATSZ_ZERO;
         end else if (pipe_ff[fat32bsc_pkg::LATE_STAGE-1].root_nz) begin
            pipe_in[fat32bsc_pkg::LATE_STAGE].status = fat32bsc_pkg::ST_ROOT_NONZERO;
         end else if (cq > fat32bsc_pkg::MAX_CLUSTERS) begin
            pipe_in[fat32bsc_pkg::LATE_STAGE].status = fat32bsc_pkg::ST_TOO_MANY;
         end else begin
            pipe_in[fat32bsc_pkg::LATE_STAGE].status = fat32bsc_pkg::ST_OK;
         end
      end
   end

   always_comb begin
      fat32bsc_pkg::pipe_type last;
      last   = pipe_ff[DEPTH-1];
      rsp_in = '0;
      rsp_in.status = last.status;
      if (last.status == fat32bsc_pkg::ST_OK) begin
         rsp_in.cluster_count       = last.cq[27:0];
         rsp_in.first_data_sector   = last.fds;
         rsp_in.cluster_bytes       = last.cbytes;
         rsp_in.entries_per_cluster = last.cbytes[15:5];
         rsp_in.volume_bytes        = last.vbytes;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DEPTH; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff        <= {vld_ff[DEPTH-2:0], req_tvalid};
         rsp_tvalid_ff <= vld_ff[DEPTH-1];
      end
   end

`ifndef SYNTHESIS
   a_error_zero_geometry : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && (rsp_ff.status != fat32bsc_pkg::ST_OK) |->
         (rsp_ff.cluster_count == '0) && (rsp_ff.first_data_sector == '0) &&
         (rsp_ff.cluster_bytes == '0) && (rsp_ff.volume_bytes == '0))
      else $error("geometry not cleared on error status");

   a_ok_is_fat32 : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && (rsp_ff.status == fat32bsc_pkg::ST_OK) |->
         (32'(rsp_ff.cluster_count) > fat32bsc_pkg::MIN_CLUSTERS) &&
         (rsp_ff.cluster_bytes != '0) &&
         (24'(rsp_ff.cluster_bytes) <= fat32bsc_pkg::MAX_CLUSTER_BYTES))
      else $error("ok status with geometry outside FAT32 limits");

   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tready |=> $stable(vld_ff) && $stable(rsp_ff))
      else $error("pipeline moved while the result was stalled");

   a_pad_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (rsp_ff.pad == 1'b0))
      else $error("result pad bit set");
`endif

endmodule
